>>> sv/b64d_pkg.sv
package b64d_pkg;

    // Alphabet offsets (standard Base64 alphabet)
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [7:0] LOWER_OFS    = 8'd26;
    localparam logic [7:0] DIGIT_OFS    = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Depth of the queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Position of the next character within its group of four
    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2,
        POS_FOURTH = 2'd3
    } pos_t;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic [5:0] sextet;   // zero when not in the alphabet
        logic       ok;       // character is in the alphabet
        logic       last;     // final character of the string
    } sym_t;

    // Queue status seen by the neighbours
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic sym_t classify(input logic [7:0] ch, input logic last);
        sym_t s;
        s.sextet = 6'd0;
        s.ok     = 1'b1;
        s.last   = last;
        if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            s.sextet = 6'(ch - CHAR_UPPER_A);
        end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            s.sextet = 6'(ch - CHAR_LOWER_A + LOWER_OFS);
        end else if (ch inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
            s.sextet = 6'(ch - CHAR_DIGIT_0 + DIGIT_OFS);
        end else if (ch == CHAR_PLUS) begin
            s.sextet = SEXTET_PLUS;
        end else if (ch == CHAR_SLASH) begin
            s.sextet = SEXTET_SLASH;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> sv/b64d_front.sv
module b64d_front
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       sym_valid,
    input  logic       sym_ready,
    output sym_t       sym
);

    logic valid_reg, valid_next;
    sym_t sym_reg;

    // stage empties or drains in the same cycle
    assign in_ready   = !valid_reg || sym_ready;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !sym_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sym_reg <= classify(char_code, last_char);
        end
    end

    assign sym_valid = valid_reg;
    assign sym       = sym_reg;

endmodule

>>> sv/b64d_fifo.sv
module b64d_fifo
    import b64d_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  sym_t    wr_data,
    input  logic    rd_en,
    output sym_t    rd_data,
    output q_stat_t stat
);

    sym_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

>>> sv/b64d_back.sv
module b64d_back
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       sym_valid,
    output logic       sym_take,
    input  sym_t       sym,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       string_end,
    output logic       halted
);

    pos_t       pos_reg, pos_next;
    logic [5:0] prev_reg, prev_next;
    logic       prev_ok_reg, prev_ok_next;
    logic       stop_reg, stop_next;
    logic       stop_now;

    logic       ovalid_reg;
    logic [7:0] obyte_reg, obyte_next;
    logic       ovld_reg, ovld_next;
    logic       oend_reg;
    logic       ohalt_reg;

    // output register frees up in the same cycle it is taken
    assign sym_take = sym_valid && (!ovalid_reg || out_ready);

    // next state
    always_comb begin
        stop_now     = stop_reg;
        pos_next     = pos_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        if (!stop_reg) begin
            case (pos_reg)
                POS_FIRST, POS_SECOND: stop_now = !sym.ok;
                default:               stop_now = 1'b0;
            endcase
            if (!stop_now) begin
                prev_next    = sym.sextet;
                prev_ok_next = sym.ok;
                pos_next     = pos_t'(pos_reg + 2'd1);
            end
        end
        stop_next = stop_now;
        if (sym.last) begin
            stop_next    = 1'b0;
            pos_next     = POS_FIRST;
            prev_next    = 6'd0;
            prev_ok_next = 1'b0;
        end
    end

    // decoded byte
    always_comb begin
        obyte_next = 8'd0;
        ovld_next  = 1'b0;
        if (!stop_reg) begin
            case (pos_reg)
                POS_SECOND: begin
                    ovld_next  = sym.ok;
                    obyte_next = {prev_reg, sym.sextet[5:4]};
                end
                POS_THIRD: begin
                    ovld_next  = sym.ok;
                    obyte_next = {prev_reg[3:0], sym.sextet[5:2]};
                end
                POS_FOURTH: begin
                    ovld_next  = sym.ok && prev_ok_reg;
                    obyte_next = {prev_reg[1:0], sym.sextet};
                end
                default: begin
                    ovld_next  = 1'b0;
                end
            endcase
        end
        if (!ovld_next) begin
            obyte_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_FIRST;
            prev_reg    <= 6'd0;
            prev_ok_reg <= 1'b0;
            stop_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end else begin
            if (sym_take) begin
                pos_reg     <= pos_next;
                prev_reg    <= prev_next;
                prev_ok_reg <= prev_ok_next;
                stop_reg    <= stop_next;
            end
            if (sym_take) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sym_take) begin
            obyte_reg <= obyte_next;
            ovld_reg  <= ovld_next;
            oend_reg  <= sym.last;
            ohalt_reg <= stop_now;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign byte_valid = ovld_reg;
    assign string_end = oend_reg;
    assign halted     = ohalt_reg;

endmodule

>>> sv/base64_decoder.sv
// Channel  | Direction | Payload                                   | Framing
// ---------+-----------+-------------------------------------------+--------------------
// s_axis   | in        | tdata[7:0] char_code                      | tlast = last_char
// m_axis   | out       | tdata[7:0] out_byte, tuser = {halted,bv}  | tlast = string_end
//
// One character per cycle sustained while m_axis_tready is high; every character gives
// one output transaction. A character passes the classify register, queue and output
// register. Reset: synchronous, active-low aresetn; clears group position, halt flag,
// queue and valid flags. Stalls: m_axis_tready low fills the output register and then
// the two-entry queue before s_axis_tready drops; the front keeps taking characters
// meanwhile.
module base64_decoder
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // last_char
    // result channel
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] halted
    output logic       m_axis_tlast    // string_end
);

    // front -> queue
    logic    front_valid;
    sym_t    front_sym;
    // queue -> back
    sym_t    q_sym;
    q_stat_t q_stat;
    logic    back_take;

    logic    byte_valid;
    logic    halted;

    // front: accepts characters and maps them to sextets
    b64d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .last_char (s_axis_tlast),
        .sym_valid (front_valid),
        .sym_ready (!q_stat.full),
        .sym       (front_sym)
    );

    // short queue so front and back stall independently
    b64d_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (front_valid && !q_stat.full),
        .wr_data (front_sym),
        .rd_en   (back_take),
        .rd_data (q_sym),
        .stat    (q_stat)
    );

    // back: group tracking, byte assembly and output register
    b64d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sym_valid  (!q_stat.empty),
        .sym_take   (back_take),
        .sym        (q_sym),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .byte_valid (byte_valid),
        .string_end (m_axis_tlast),
        .halted     (halted)
    );

    assign m_axis_tuser = {halted, byte_valid};

`ifndef SYNTHESIS
    // a decoded byte never comes out of a halted string
    a_byte_not_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && byte_valid) |-> !halted)
        else $error("byte reported together with halt");

    // suppressed bytes read as zero
    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !byte_valid) |-> (m_axis_tdata == 8'd0))
        else $error("non-zero data on suppressed byte");

    // queue occupancy stays within its depth and flags agree
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.count <= QCNT_W'(QDEPTH)) && !(q_stat.full && q_stat.empty))
        else $error("queue occupancy out of range");

    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        back_take |-> !q_stat.empty)
        else $error("queue read while empty");
`endif

endmodule
